// ===== rtl/core/rrco_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrco_pkg: shared types and constants of the rotated rectangle overlap unit
// Fixed widths, angle constants, configuration register codes and the
// geometry bundle that rides along the pipeline.
// ---------------------------------------------------------------------------
package rrco_pkg;

  // Default number of quarter-wave sine intervals.
  localparam int SINE_QUARTER_ENTRIES_DEF = 1024;

  // Angles are counted in sixteenths of a degree.
  localparam int TURN_UNITS    = 5760;
  localparam int QUARTER_UNITS = 1440;

  // pi/2 in Q2.30, the argument scale of the sine series.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Field widths.
  localparam int COORD_W = 16;  // signed Q12.4 coordinate
  localparam int LEN_W   = 15;  // unsigned Q11.4 length
  localparam int ROT_W   = 13;  // rotation code
  localparam int RATIO_W = 16;  // unsigned Q4.12 ratio
  localparam int CFG_W   = 16;  // configuration write data

  // Internal widths.
  localparam int QANG_W = 11;  // angle inside one quadrant, 0..1440
  localparam int HALF_W = 18;  // coordinate in half Q12.4 units
  localparam int DIFF_W = 19;  // circle centre minus rectangle centre
  localparam int SINE_W = 15;  // magnitude of a quarter-wave entry
  localparam int TRIG_W = 16;  // signed Q1.15 sine or cosine
  localparam int PROD_W = 35;  // trig times offset
  localparam int ACC_W  = 37;  // sum of two products plus rounding bias
  localparam int LOC_W  = 23;  // rotated location in half units
  localparam int ERR_W  = 20;  // distance from the clamped point
  localparam int SQ_W   = 40;  // squared distance per axis
  localparam int RP_W   = 31;  // base radius times ratio
  localparam int RAD_W  = 33;  // boosted radius, signed
  localparam int RMAG_W = 32;  // magnitude of the boosted radius
  localparam int RAD2_W = 64;  // squared boosted radius

  // Configuration register codes.
  typedef enum logic [1:0] {
    CFG_CENTER_X    = 2'd0,
    CFG_CENTER_Y    = 2'd1,
    CFG_BASE_RADIUS = 2'd2,
    CFG_SEES_HIDDEN = 2'd3
  } cfg_reg_t;

  // Quadrant of the rotation angle.
  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quadrant_t;

  // Rectangle centre and bounds, all in half Q12.4 units.
  typedef struct packed {
    logic signed [HALF_W-1:0] mx;
    logic signed [HALF_W-1:0] my;
    logic signed [HALF_W-1:0] xlo;
    logic signed [HALF_W-1:0] xhi;
    logic signed [HALF_W-1:0] ylo;
    logic signed [HALF_W-1:0] yhi;
  } geom_t;

  // Centre offset of the circle from the rectangle centre.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } offset_t;

endpackage

// ===== rtl/core/rotated_rect_circle_overlap_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotated_rect_circle_overlap_unit: circle against rotated rectangle test
// Rotates the configured circle centre into the frame of each rectangle,
// clamps it to the rectangle and compares the squared distance with the
// squared boosted radius; applies the hidden-target rule on top.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake            | Content
//  ---------+-----------+----------------------+--------------------------------
//  in_      | slave     | in_tvalid/in_tready  | one rectangle request per item
//  out_     | master    | out_tvalid/out_tready| overlap flags, one item per request
//  cfg_     | slave     | cfg_valid/cfg_ready  | register index and write data
//
//  The unit is an eleven-stage pipeline: a request enters every cycle while
//  the pipeline is not held. The depth is set by the angle index divider
//  (reciprocal multiply and correction), the registered sine table read and
//  the two rounds of multiplication for rotation and squaring. Reset (rst_n
//  low at a clock edge) empties the pipeline and clears all configuration
//  registers. When the output item is not taken, the whole pipeline holds and
//  in_tready drops; no item is lost or repeated. Configuration writes are
//  always accepted: cfg_ready is held high.
//
module rotated_rect_circle_overlap_unit #(
  parameter int SINE_QUARTER_ENTRIES = rrco_pkg::SINE_QUARTER_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // From bit 0: rect_x[15:0], rect_y[31:16], rect_width[46:32],
  // rect_height[61:47], rotation[74:62], radius_ratio[90:75],
  // radius_add[106:91], zero fill[111:107].
  input  logic [111:0] in_tdata,
  // From bit 0: target_hidden[0], boost_sees_hidden[1].
  input  logic [1:0]   in_tuser,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // From bit 0: overlaps[0], hidden_rejected[1], zero fill[7:2].
  output logic [7:0]   out_tdata,
  // Configuration channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // -------------------------------------------------------------------------
  // Derived sizes
  // -------------------------------------------------------------------------
  localparam int NUM_STAGES = 11;
  // Table index covers 0..SINE_QUARTER_ENTRIES.
  localparam int IW = $clog2(SINE_QUARTER_ENTRIES + 1);
  // Numerator of the index division: r*N + 720.
  localparam int XW = $clog2(rrco_pkg::QUARTER_UNITS * SINE_QUARTER_ENTRIES
                             + rrco_pkg::QUARTER_UNITS / 2 + 1);
  // Division by 1440 as a multiply by floor(2^34 / 1440) and a shift; the
  // estimate is the true quotient or one less, fixed by one compare.
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / rrco_pkg::QUARTER_UNITS);
  localparam int MULW = XW + RECIP_W;

  localparam logic [XW-1:0] HALF_QUARTER = XW'(rrco_pkg::QUARTER_UNITS / 2);
  localparam logic [XW-1:0] ENTRIES_X    = XW'(SINE_QUARTER_ENTRIES);
  localparam logic signed [rrco_pkg::ACC_W-1:0] ROUND_HALF = 16384;

  // -------------------------------------------------------------------------
  // Quarter-wave sine table, built at elaboration. Entry i is
  // round(sin(i/N * 90 deg) * 32768) saturated to 32767, from a Taylor
  // series evaluated in Q2.30.
  // -------------------------------------------------------------------------
  typedef logic [rrco_pkg::SINE_W-1:0] sine_rom_t [SINE_QUARTER_ENTRIES+1];

  function automatic logic [rrco_pkg::SINE_W-1:0] sine_entry(input int unsigned idx);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    if (idx == 0) begin
      return '0;
    end
    x    = (64'(idx) * rrco_pkg::HALF_PI_Q30) / SINE_QUARTER_ENTRIES;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      return '0;
    end
    sum = (sum + 16384) >>> 15;
    return (sum > 32767) ? {rrco_pkg::SINE_W{1'b1}} : rrco_pkg::SINE_W'(sum);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int i = 0; i <= SINE_QUARTER_ENTRIES; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // -------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty,
  // so the first stages may read them directly; the block does not enforce it.
  // -------------------------------------------------------------------------
  logic signed [rrco_pkg::COORD_W-1:0] cx_r;
  logic signed [rrco_pkg::COORD_W-1:0] cy_r;
  logic [rrco_pkg::LEN_W-1:0]          radius_r;
  logic                                sees_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      radius_r <= '0;
      sees_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (rrco_pkg::cfg_reg_t'(cfg_index))
        rrco_pkg::CFG_CENTER_X:    cx_r     <= cfg_data;
        rrco_pkg::CFG_CENTER_Y:    cy_r     <= cfg_data;
        rrco_pkg::CFG_BASE_RADIUS: radius_r <= cfg_data[rrco_pkg::LEN_W-1:0];
        rrco_pkg::CFG_SEES_HIDDEN: sees_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Pipeline control. Every stage advances together whenever the output
  // register is empty or being drained; valid bits shift with the data.
  // -------------------------------------------------------------------------
  logic                  adv;
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;

  assign adv       = !valid_r[NUM_STAGES-1] || out_tready;
  assign in_tready = adv;
  assign valid_nxt = {valid_r[NUM_STAGES-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Input field unpacking
  // -------------------------------------------------------------------------
  logic signed [rrco_pkg::COORD_W-1:0] rect_x;
  logic signed [rrco_pkg::COORD_W-1:0] rect_y;
  logic [rrco_pkg::LEN_W-1:0]          rect_width;
  logic [rrco_pkg::LEN_W-1:0]          rect_height;
  logic [rrco_pkg::ROT_W-1:0]          rotation;
  logic [rrco_pkg::RATIO_W-1:0]        radius_ratio;
  logic signed [rrco_pkg::COORD_W-1:0] radius_add;
  logic                                target_hidden;
  logic                                boost_sees_hidden;

  assign rect_x            = in_tdata[15:0];
  assign rect_y            = in_tdata[31:16];
  assign rect_width        = in_tdata[46:32];
  assign rect_height       = in_tdata[61:47];
  assign rotation          = in_tdata[74:62];
  assign radius_ratio      = in_tdata[90:75];
  assign radius_add        = in_tdata[106:91];
  assign target_hidden     = in_tuser[0];
  assign boost_sees_hidden = in_tuser[1];

  // -------------------------------------------------------------------------
  // Pipeline registers. An array index names the stage that loads it.
  // -------------------------------------------------------------------------
  rrco_pkg::geom_t                      geom_r   [1:8];
  rrco_pkg::offset_t                    off_r    [2:5];
  rrco_pkg::quadrant_t                  quad_r   [2:5];
  logic                                 allow_r  [1:10];
  logic [rrco_pkg::RAD2_W-1:0]          rad2_r   [3:10];

  logic [rrco_pkg::ROT_W-1:0]           rot1_r;
  logic [rrco_pkg::RP_W-1:0]            rp1_r;
  logic signed [rrco_pkg::COORD_W-1:0]  add1_r;
  logic [XW-1:0]                        xa2_r, xb2_r, xa3_r, xb3_r;
  logic [rrco_pkg::RMAG_W-1:0]          rmag2_r;
  logic [IW-1:0]                        qa3_r, qb3_r;
  logic [IW-1:0]                        ia4_r, ib4_r;
  logic [rrco_pkg::SINE_W-1:0]          ta5_r, tb5_r;
  logic signed [rrco_pkg::PROD_W-1:0]   cdx6_r, sdy6_r, sdx6_r, cdy6_r;
  logic signed [rrco_pkg::ACC_W-1:0]    vx7_r, vy7_r;
  logic signed [rrco_pkg::LOC_W-1:0]    lx8_r, ly8_r;
  logic signed [rrco_pkg::ERR_W-1:0]    ex9_r, ey9_r;
  logic signed [rrco_pkg::SQ_W-1:0]     sqx10_r, sqy10_r;
  logic                                 overlaps_r, hidden_rej_r;

  // Stage 1: fold the rotation into one turn, form the rectangle centre and
  // bounds in half units, start the radius boost, resolve the hidden rule.
  rrco_pkg::geom_t                     geom_nxt;
  logic [rrco_pkg::ROT_W-1:0]          rot1_nxt;
  logic [rrco_pkg::RP_W-1:0]           rp1_nxt;
  logic                                allow_nxt;
  logic signed [rrco_pkg::HALF_W-1:0]  x2, y2, w1, h1, w2, h2;

  always_comb begin
    x2 = {{(rrco_pkg::HALF_W-rrco_pkg::COORD_W-1){rect_x[rrco_pkg::COORD_W-1]}},
          rect_x, 1'b0};
    y2 = {{(rrco_pkg::HALF_W-rrco_pkg::COORD_W-1){rect_y[rrco_pkg::COORD_W-1]}},
          rect_y, 1'b0};
    w1 = signed'(rrco_pkg::HALF_W'(rect_width));
    h1 = signed'(rrco_pkg::HALF_W'(rect_height));
    w2 = w1 <<< 1;
    h2 = h1 <<< 1;
    geom_nxt.mx  = x2 + w1;
    geom_nxt.my  = y2 + h1;
    geom_nxt.xlo = x2;
    geom_nxt.xhi = x2 + w2;
    geom_nxt.ylo = y2;
    geom_nxt.yhi = y2 + h2;
    if (rotation >= rrco_pkg::ROT_W'(rrco_pkg::TURN_UNITS)) begin
      rot1_nxt = rotation - rrco_pkg::ROT_W'(rrco_pkg::TURN_UNITS);
    end else begin
      rot1_nxt = rotation;
    end
    rp1_nxt   = rrco_pkg::RP_W'(radius_r) * rrco_pkg::RP_W'(radius_ratio);
    allow_nxt = !target_hidden || sees_r || boost_sees_hidden;
  end

  // Stage 2: split the angle into quadrant and remainder, build both index
  // numerators, the circle offset from the centre and the radius magnitude.
  rrco_pkg::quadrant_t                quad_nxt;
  logic [rrco_pkg::ROT_W-1:0]         quad_base;
  logic [rrco_pkg::QANG_W-1:0]        r_ang, r_mirror;
  logic [XW-1:0]                      xa2_nxt, xb2_nxt;
  rrco_pkg::offset_t                  off_nxt;
  logic signed [rrco_pkg::HALF_W-1:0] cx2, cy2;
  logic signed [rrco_pkg::RAD_W-1:0]  rad;
  logic [rrco_pkg::RMAG_W-1:0]        rmag2_nxt;

  always_comb begin
    if (rot1_r < rrco_pkg::ROT_W'(rrco_pkg::QUARTER_UNITS)) begin
      quad_nxt  = rrco_pkg::QUAD_FIRST;
      quad_base = '0;
    end else if (rot1_r < rrco_pkg::ROT_W'(2 * rrco_pkg::QUARTER_UNITS)) begin
      quad_nxt  = rrco_pkg::QUAD_SECOND;
      quad_base = rrco_pkg::ROT_W'(rrco_pkg::QUARTER_UNITS);
    end else if (rot1_r < rrco_pkg::ROT_W'(3 * rrco_pkg::QUARTER_UNITS)) begin
      quad_nxt  = rrco_pkg::QUAD_THIRD;
      quad_base = rrco_pkg::ROT_W'(2 * rrco_pkg::QUARTER_UNITS);
    end else begin
      quad_nxt  = rrco_pkg::QUAD_FOURTH;
      quad_base = rrco_pkg::ROT_W'(3 * rrco_pkg::QUARTER_UNITS);
    end
    r_ang    = rrco_pkg::QANG_W'(rot1_r - quad_base);
    r_mirror = rrco_pkg::QANG_W'(rrco_pkg::QUARTER_UNITS) - r_ang;
    xa2_nxt  = XW'(r_ang) * ENTRIES_X + HALF_QUARTER;
    xb2_nxt  = XW'(r_mirror) * ENTRIES_X + HALF_QUARTER;

    cx2 = {{(rrco_pkg::HALF_W-rrco_pkg::COORD_W-1){cx_r[rrco_pkg::COORD_W-1]}},
           cx_r, 1'b0};
    cy2 = {{(rrco_pkg::HALF_W-rrco_pkg::COORD_W-1){cy_r[rrco_pkg::COORD_W-1]}},
           cy_r, 1'b0};
    off_nxt.dx = rrco_pkg::DIFF_W'(cx2) - rrco_pkg::DIFF_W'(geom_r[1].mx);
    off_nxt.dy = rrco_pkg::DIFF_W'(cy2) - rrco_pkg::DIFF_W'(geom_r[1].my);

    // base*ratio is in 1/65536 px; the addend moves there by 12 bits.
    rad = signed'({2'b00, rp1_r}) + (rrco_pkg::RAD_W'(add1_r) <<< 12);
    rmag2_nxt = (rad < 0) ? rrco_pkg::RMAG_W'(-rad) : rrco_pkg::RMAG_W'(rad);
  end

  // Stage 3: reciprocal multiply for both indexes; square the radius.
  logic [MULW-1:0]               pa, pb;
  logic [IW-1:0]                 qa3_nxt, qb3_nxt;
  logic [rrco_pkg::RAD2_W-1:0]   rad2_nxt;

  always_comb begin
    pa       = MULW'(xa2_r) * MULW'(RECIP);
    pb       = MULW'(xb2_r) * MULW'(RECIP);
    qa3_nxt  = IW'(pa >> RECIP_SHIFT);
    qb3_nxt  = IW'(pb >> RECIP_SHIFT);
    rad2_nxt = rrco_pkg::RAD2_W'(rmag2_r) * rrco_pkg::RAD2_W'(rmag2_r);
  end

  // Stage 4: correct the quotient estimates by one where the remainder
  // still holds a full divisor.
  logic [XW:0]   rema, remb;
  logic [IW-1:0] ia4_nxt, ib4_nxt;

  always_comb begin
    rema    = (XW+1)'(xa3_r) - (XW+1)'(qa3_r) * (XW+1)'(rrco_pkg::QUARTER_UNITS);
    remb    = (XW+1)'(xb3_r) - (XW+1)'(qb3_r) * (XW+1)'(rrco_pkg::QUARTER_UNITS);
    ia4_nxt = (rema >= (XW+1)'(rrco_pkg::QUARTER_UNITS)) ? qa3_r + IW'(1) : qa3_r;
    ib4_nxt = (remb >= (XW+1)'(rrco_pkg::QUARTER_UNITS)) ? qb3_r + IW'(1) : qb3_r;
  end

  // Stage 6: quadrant selection and the four rotation products. The circle
  // centre turns by the negative angle, so s is minus the sine.
  logic signed [rrco_pkg::TRIG_W-1:0]  ta_s, tb_s, c_t, s_t;
  logic signed [rrco_pkg::PROD_W-1:0]  cdx_nxt, sdy_nxt, sdx_nxt, cdy_nxt;

  always_comb begin
    ta_s = signed'({1'b0, ta5_r});
    tb_s = signed'({1'b0, tb5_r});
    case (quad_r[5])
      rrco_pkg::QUAD_FIRST: begin
        s_t = -ta_s;
        c_t = tb_s;
      end
      rrco_pkg::QUAD_SECOND: begin
        s_t = -tb_s;
        c_t = -ta_s;
      end
      rrco_pkg::QUAD_THIRD: begin
        s_t = ta_s;
        c_t = -tb_s;
      end
      default: begin
        s_t = tb_s;
        c_t = ta_s;
      end
    endcase
    cdx_nxt = c_t * off_r[5].dx;
    sdy_nxt = s_t * off_r[5].dy;
    sdx_nxt = s_t * off_r[5].dx;
    cdy_nxt = c_t * off_r[5].dy;
  end

  // Stage 7: combine products and add the rounding bias (ties go upward).
  logic signed [rrco_pkg::ACC_W-1:0] vx_nxt, vy_nxt;

  always_comb begin
    vx_nxt = rrco_pkg::ACC_W'(cdx6_r) - rrco_pkg::ACC_W'(sdy6_r) + ROUND_HALF;
    vy_nxt = rrco_pkg::ACC_W'(sdx6_r) + rrco_pkg::ACC_W'(cdy6_r) + ROUND_HALF;
  end

  // Stage 8: drop the Q1.15 fraction and move back to absolute position.
  logic signed [rrco_pkg::ACC_W-1:0] vx_sh, vy_sh;
  logic signed [rrco_pkg::LOC_W-1:0] lx_nxt, ly_nxt;

  always_comb begin
    vx_sh  = vx7_r >>> 15;
    vy_sh  = vy7_r >>> 15;
    lx_nxt = rrco_pkg::LOC_W'(vx_sh) + rrco_pkg::LOC_W'(geom_r[7].mx);
    ly_nxt = rrco_pkg::LOC_W'(vy_sh) + rrco_pkg::LOC_W'(geom_r[7].my);
  end

  // Stage 9: distance from the rotated point to the rectangle, per axis.
  // The centre lies inside the bounds, so the distance never exceeds the
  // rotated offset and fits the narrow width.
  logic signed [rrco_pkg::LOC_W-1:0] xlo_l, xhi_l, ylo_l, yhi_l;
  logic signed [rrco_pkg::LOC_W-1:0] ex_full, ey_full;

  always_comb begin
    xlo_l = rrco_pkg::LOC_W'(geom_r[8].xlo);
    xhi_l = rrco_pkg::LOC_W'(geom_r[8].xhi);
    ylo_l = rrco_pkg::LOC_W'(geom_r[8].ylo);
    yhi_l = rrco_pkg::LOC_W'(geom_r[8].yhi);
    if (lx8_r > xhi_l) begin
      ex_full = lx8_r - xhi_l;
    end else if (lx8_r < xlo_l) begin
      ex_full = lx8_r - xlo_l;
    end else begin
      ex_full = '0;
    end
    if (ly8_r > yhi_l) begin
      ey_full = ly8_r - yhi_l;
    end else if (ly8_r < ylo_l) begin
      ey_full = ly8_r - ylo_l;
    end else begin
      ey_full = '0;
    end
  end

  // Stage 11: squared distance against squared radius, scaled so both are
  // in the same units (2^22 = 65536^2 / 32^2), then the hidden rule.
  logic [rrco_pkg::SQ_W:0]     dist2;
  logic [rrco_pkg::RAD2_W-1:0] dist2_scaled;
  logic                        geo;
  logic                        overlaps_nxt, hidden_rej_nxt;

  always_comb begin
    dist2 = (rrco_pkg::SQ_W+1)'(unsigned'(sqx10_r))
          + (rrco_pkg::SQ_W+1)'(unsigned'(sqy10_r));
    dist2_scaled   = rrco_pkg::RAD2_W'(dist2) << 22;
    geo            = dist2_scaled <= rad2_r[10];
    overlaps_nxt   = geo && allow_r[10];
    hidden_rej_nxt = geo && !allow_r[10];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1
      geom_r[1]  <= geom_nxt;
      allow_r[1] <= allow_nxt;
      rot1_r     <= rot1_nxt;
      rp1_r      <= rp1_nxt;
      add1_r     <= radius_add;
      // Stage 2
      quad_r[2]  <= quad_nxt;
      off_r[2]   <= off_nxt;
      xa2_r      <= xa2_nxt;
      xb2_r      <= xb2_nxt;
      rmag2_r    <= rmag2_nxt;
      // Stage 3
      qa3_r      <= qa3_nxt;
      qb3_r      <= qb3_nxt;
      xa3_r      <= xa2_r;
      xb3_r      <= xb2_r;
      rad2_r[3]  <= rad2_nxt;
      // Stage 4
      ia4_r      <= ia4_nxt;
      ib4_r      <= ib4_nxt;
      // Stage 5: sine table read
      ta5_r      <= SINE_ROM[ia4_r];
      tb5_r      <= SINE_ROM[ib4_r];
      // Stage 6
      cdx6_r     <= cdx_nxt;
      sdy6_r     <= sdy_nxt;
      sdx6_r     <= sdx_nxt;
      cdy6_r     <= cdy_nxt;
      // Stage 7
      vx7_r      <= vx_nxt;
      vy7_r      <= vy_nxt;
      // Stage 8
      lx8_r      <= lx_nxt;
      ly8_r      <= ly_nxt;
      // Stage 9
      ex9_r      <= rrco_pkg::ERR_W'(ex_full);
      ey9_r      <= rrco_pkg::ERR_W'(ey_full);
      // Stage 10
      sqx10_r    <= ex9_r * ex9_r;
      sqy10_r    <= ey9_r * ey9_r;
      // Stage 11: output register
      overlaps_r   <= overlaps_nxt;
      hidden_rej_r <= hidden_rej_nxt;

      // Side data riding along with the item.
      for (int k = 2; k <= 8; k++) begin
        geom_r[k] <= geom_r[k-1];
      end
      for (int k = 3; k <= 5; k++) begin
        off_r[k]  <= off_r[k-1];
        quad_r[k] <= quad_r[k-1];
      end
      for (int k = 2; k <= 10; k++) begin
        allow_r[k] <= allow_r[k-1];
      end
      for (int k = 4; k <= 10; k++) begin
        rad2_r[k] <= rad2_r[k-1];
      end
    end
  end

  assign out_tvalid = valid_r[NUM_STAGES-1];
  assign out_tdata  = {6'b000000, hidden_rej_r, overlaps_r};

endmodule

// ===== bench/tb_rotated_rect_circle_overlap_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rotated_rect_circle_overlap_unit: self-checking bench for the overlap unit
// Streams rectangle requests through the unit while the result side stalls,
// predicts each overlap and hidden-target flag with a fixed-point model of its
// own and checks every result item in order against that prediction.
// ---------------------------------------------------------------------------
module tb_rotated_rect_circle_overlap_unit;

  localparam int SINE_STEPS     = rrco_pkg::SINE_QUARTER_ENTRIES_DEF;
  localparam int PIPE_DEPTH     = 11;
  localparam int SETTLE_CYCLES  = PIPE_DEPTH + 4;
  localparam int QUIET_LIMIT    = 4000;
  localparam int RESET_CYCLES   = 11;

  // One rectangle request, laid out field by field.
  typedef struct {
    logic signed [rrco_pkg::COORD_W-1:0] rect_x;
    logic signed [rrco_pkg::COORD_W-1:0] rect_y;
    logic        [rrco_pkg::LEN_W-1:0]   rect_width;
    logic        [rrco_pkg::LEN_W-1:0]   rect_height;
    logic        [rrco_pkg::ROT_W-1:0]   rotation;
    logic                                target_hidden;
    logic                                boost_sees_hidden;
    logic        [rrco_pkg::RATIO_W-1:0] radius_ratio;
    logic signed [rrco_pkg::COORD_W-1:0] radius_add;
  } rect_request_t;

  // Result flags in the bit order of out_tdata.
  typedef struct packed {
    logic hidden_rejected;
    logic overlaps;
  } overlap_flags_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [111:0]       in_tdata = '0;
  logic [1:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  rrco_pkg::cfg_reg_t cfg_index = rrco_pkg::CFG_CENTER_X;
  logic [15:0]        cfg_data = '0;

  // Mirror of the configuration registers, updated as each write is taken.
  int   circle_x = 0;
  int   circle_y = 0;
  int   base_radius = 0;
  logic sees_hidden = 1'b0;

  overlap_flags_t expected_flags[$];
  overlap_flags_t oldest_flags;
  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int overlap_hits = 0;
  int hidden_rejects = 0;
  int config_writes = 0;
  int burst_left = 0;
  int ready_cycle = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  rotated_rect_circle_overlap_unit #(
    .SINE_QUARTER_ENTRIES(SINE_STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Q1.15 sine of an angle inside one quadrant (0..1440 sixteenths of a
  // degree), taken from the quarter-wave table that the series defines.
  function automatic longint quarter_wave_sine(int quad_angle);
    longint unsigned idx, x, term;
    longint sum;
    idx = (longint'(quad_angle) * SINE_STEPS + rrco_pkg::QUARTER_UNITS / 2)
          / rrco_pkg::QUARTER_UNITS;
    if (idx == 0) return 0;
    if (idx > SINE_STEPS) idx = SINE_STEPS;
    x = idx * rrco_pkg::HALF_PI_Q30 / longint'(SINE_STEPS);
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) return 0;
    sum = (sum + 16384) >>> 15;
    return (sum > 32767) ? 32767 : sum;
  endfunction

  // Expected flags of one request under the current configuration mirror.
  function automatic overlap_flags_t predict_overlap(rect_request_t req);
    int rot, quad_angle;
    rrco_pkg::quadrant_t quad;
    longint ta, tb, sin_t, cos_t, s, c;
    longint rx, ry, w, h, mx, my, dx, dy, lx, ly, px, py, ex, ey, rad;
    longint unsigned dist2, rmag, rad2;
    logic geo, allowed;
    overlap_flags_t res;
    rot = int'(req.rotation) % rrco_pkg::TURN_UNITS;
    quad = rrco_pkg::quadrant_t'(rot / rrco_pkg::QUARTER_UNITS);
    quad_angle = rot % rrco_pkg::QUARTER_UNITS;
    ta = quarter_wave_sine(quad_angle);
    tb = quarter_wave_sine(rrco_pkg::QUARTER_UNITS - quad_angle);
    case (quad)
      rrco_pkg::QUAD_FIRST: begin
        sin_t = ta;  cos_t = tb;
      end
      rrco_pkg::QUAD_SECOND: begin
        sin_t = tb;  cos_t = -ta;
      end
      rrco_pkg::QUAD_THIRD: begin
        sin_t = -ta; cos_t = -tb;
      end
      default: begin
        sin_t = -tb; cos_t = ta;
      end
    endcase
    // The circle is turned by the negative angle, so the sine flips sign.
    s = -sin_t;
    c = cos_t;
    // Geometry in half Q12.4 units keeps the rectangle center exact.
    rx = req.rect_x;
    ry = req.rect_y;
    w = req.rect_width;
    h = req.rect_height;
    mx = 2 * rx + w;
    my = 2 * ry + h;
    dx = 2 * longint'(circle_x) - mx;
    dy = 2 * longint'(circle_y) - my;
    // Round to the nearest half unit, ties toward plus infinity.
    lx = ((c * dx - s * dy + 16384) >>> 15) + mx;
    ly = ((s * dx + c * dy + 16384) >>> 15) + my;
    px = lx;
    if (px > 2 * rx + 2 * w) px = 2 * rx + 2 * w;
    if (px < 2 * rx) px = 2 * rx;
    py = ly;
    if (py > 2 * ry + 2 * h) py = 2 * ry + 2 * h;
    if (py < 2 * ry) py = 2 * ry;
    ex = lx - px;
    ey = ly - py;
    dist2 = ex * ex + ey * ey;
    // Boosted radius in 1/65536 pixel; only its magnitude counts.
    rad = longint'(base_radius) * longint'(req.radius_ratio)
        + longint'(req.radius_add) * 4096;
    rmag = (rad < 0) ? -rad : rad;
    rad2 = rmag * rmag;
    geo = (dist2 << 22) <= rad2;
    allowed = !req.target_hidden || sees_hidden || req.boost_sees_hidden;
    res.overlaps = geo && allowed;
    res.hidden_rejected = geo && !allowed;
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic rect_request_t make_rect(int x, int y, int w, int h, int rot,
                                              bit hidden, bit boost, int ratio, int add);
    rect_request_t req;
    req.rect_x = x[15:0];
    req.rect_y = y[15:0];
    req.rect_width = w[14:0];
    req.rect_height = h[14:0];
    req.rotation = rot[12:0];
    req.target_hidden = hidden;
    req.boost_sees_hidden = boost;
    req.radius_ratio = ratio[15:0];
    req.radius_add = add[15:0];
    return req;
  endfunction

  // Most requests place a moderate rectangle around the circle so that hits
  // and misses are both common; the rest are raw bit patterns.
  function automatic rect_request_t random_rect();
    rect_request_t req;
    int w, h, span;
    span = base_radius * 3 + 256;
    if (span > 40000) span = 40000;
    if ($urandom_range(0, 3) != 0) begin
      w = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 1600);
      h = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 1600);
      req.rect_width = w[14:0];
      req.rect_height = h[14:0];
      req.rect_x = clamp16(circle_x - w / 2 + int'($urandom_range(0, 2 * span)) - span);
      req.rect_y = clamp16(circle_y - h / 2 + int'($urandom_range(0, 2 * span)) - span);
      req.rotation = rrco_pkg::ROT_W'($urandom);
      req.radius_ratio = rrco_pkg::RATIO_W'($urandom_range(1024, 12288));
      req.radius_add = rrco_pkg::COORD_W'(int'($urandom_range(0, 1024)) - 512);
    end else begin
      req.rect_x = rrco_pkg::COORD_W'($urandom);
      req.rect_y = rrco_pkg::COORD_W'($urandom);
      req.rect_width = rrco_pkg::LEN_W'($urandom);
      req.rect_height = rrco_pkg::LEN_W'($urandom);
      req.rotation = rrco_pkg::ROT_W'($urandom);
      req.radius_ratio = rrco_pkg::RATIO_W'($urandom);
      req.radius_add = rrco_pkg::COORD_W'($urandom);
    end
    req.target_hidden = 1'($urandom_range(0, 1));
    req.boost_sees_hidden = 1'($urandom_range(0, 1));
    return req;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Offers one request and waits until it is taken. Valid stays high inside a
  // burst; a burst ends with a random gap before the next item is offered.
  task automatic send_rect(rect_request_t req);
    in_tdata <= {5'b0, req.radius_add, req.radius_ratio, req.rotation,
                 req.rect_height, req.rect_width, req.rect_y, req.rect_x};
    in_tuser <= {req.boost_sees_hidden, req.target_hidden};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_flags.push_back(predict_overlap(req));
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 10);
    end
  endtask

  // Lets every outstanding result come back, then waits for the pipeline to settle.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back; valid drops once at the end.
  task automatic set_circle(int cx, int cy, logic [15:0] radius_word,
                            logic [15:0] sees_word);
    rrco_pkg::cfg_reg_t regs[4];
    logic [15:0] words[4];
    regs = '{rrco_pkg::CFG_CENTER_X, rrco_pkg::CFG_CENTER_Y,
             rrco_pkg::CFG_BASE_RADIUS, rrco_pkg::CFG_SEES_HIDDEN};
    words = '{cx[15:0], cy[15:0], radius_word, sees_word};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data <= words[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      config_writes++;
      case (regs[i])
        rrco_pkg::CFG_CENTER_X:    circle_x = int'(signed'(words[i]));
        rrco_pkg::CFG_CENTER_Y:    circle_y = int'(signed'(words[i]));
        rrco_pkg::CFG_BASE_RADIUS: base_radius = int'(words[i][14:0]);
        default:                   sees_hidden = words[i][0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Registers still at their reset values: zero radius, circle at the origin.
  task automatic test_reset_defaults();
    send_rect(make_rect(-16, -16, 32, 32, 0, 0, 0, 4096, 0));
    send_rect(make_rect(64, 64, 16, 16, 0, 0, 0, 4096, 0));
  endtask

  // A one-pixel circle that just touches the right edge of the rectangle;
  // the equal case must count as an overlap.
  task automatic test_touching_boundary();
    drain_pipeline();
    set_circle(0, 0, 16'd16, 16'd0);
    send_rect(make_rect(-32, -8, 16, 16, 0, 0, 0, 4096, 0));
    send_rect(make_rect(-32, -8, 16, 16, 0, 0, 0, 4095, 0));
    send_rect(make_rect(-32, -8, 16, 16, 0, 0, 0, 4095, 1));
    // Negative boosted radius works through its magnitude.
    send_rect(make_rect(-32, -8, 16, 16, 0, 0, 0, 0, -16));
    send_rect(make_rect(-32, -8, 16, 16, 0, 1, 0, 4096, 0));
    send_rect(make_rect(-32, -8, 16, 16, 0, 1, 1, 4096, 0));
  endtask

  // A long thin bar beside the circle, turned into every quadrant, onto the
  // quadrant seams and past one full turn.
  task automatic test_rotation_quadrants();
    int angles[8];
    angles = '{0, 1439, 1440, 2880, 4320, 5759, 5760, 8191};
    foreach (angles[i]) send_rect(make_rect(16, -64, 160, 32, angles[i], 0, 0, 4096, 0));
  endtask

  // Zero-size rectangles and the extreme values of every field.
  task automatic test_degenerate_and_extreme_fields();
    send_rect(make_rect(0, -8, 0, 16, 0, 0, 0, 4096, 0));
    send_rect(make_rect(0, 0, 0, 0, 720, 0, 0, 4096, 0));
    send_rect(make_rect(-32768, -32768, 32767, 32767, 0, 0, 0, 65535, 32767));
    send_rect(make_rect(32767, 32767, 0, 0, 5759, 1, 1, 0, -32768));
    send_rect(make_rect(-32768, 32767, 32767, 0, 8191, 1, 0, 65535, -32768));
  endtask

  // With the configuration allowing hidden targets, the request flag is moot.
  task automatic test_hidden_rule();
    drain_pipeline();
    set_circle(0, 0, 16'd16, 16'd1);
    send_rect(make_rect(-32, -8, 16, 16, 0, 1, 0, 4096, 0));
    send_rect(make_rect(-64, -8, 16, 16, 0, 1, 0, 4096, 0));
  endtask

  // Random requests over several circle settings, extremes included.
  task automatic test_random_sweep(int items_per_setting);
    for (int p = 0; p < 6; p++) begin
      drain_pipeline();
      case (p)
        0: set_circle(0, 0, 16'd800, 16'd0);
        1: set_circle(-32768, 32767, 16'hFFFF, 16'd1);
        2: set_circle(32767, -32768, 16'd0, 16'd0);
        default: set_circle(int'($urandom_range(0, 40000)) - 20000,
                            int'($urandom_range(0, 40000)) - 20000,
                            16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1)));
      endcase
      repeat (items_per_setting) send_rect(random_rect());
    end
  endtask

  // Result checker and receiver stall pattern. The pattern rotates through
  // always ready, coin flips, a long periodic stall and light random stalls.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_flags.size() == 0) begin
        report_mismatch($sformatf("result %b with no request pending", out_tdata[1:0]));
      end else begin
        oldest_flags = expected_flags.pop_front();
        results_checked++;
        if (oldest_flags.overlaps) overlap_hits++;
        if (oldest_flags.hidden_rejected) hidden_rejects++;
        if (out_tdata[0] !== oldest_flags.overlaps)
          report_mismatch($sformatf("result %0d overlaps: want %b got %b",
                                    results_checked, oldest_flags.overlaps, out_tdata[0]));
        if (out_tdata[1] !== oldest_flags.hidden_rejected)
          report_mismatch($sformatf("result %0d hidden_rejected: want %b got %b",
                                    results_checked, oldest_flags.hidden_rejected,
                                    out_tdata[1]));
      end
    end
    case ((ready_cycle / 97) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (ready_cycle % 32) >= 12;
      default: out_tready <= $urandom_range(0, 3) != 0;
    endcase
    ready_cycle++;
  end

  // Watchdog: too long without any handshake on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_touching_boundary();
    test_rotation_quadrants();
    test_degenerate_and_extreme_fields();
    test_hidden_rule();
    test_random_sweep(150);
    drain_pipeline();
    $display("Covered %0d requests over %0d register writes; %0d results checked.",
             requests_sent, config_writes, results_checked);
    $display("Overlaps seen: %0d, hidden-target rejections: %0d, mismatches: %0d.",
             overlap_hits, hidden_rejects, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rrco_pkg.sv
rtl/core/rotated_rect_circle_overlap_unit.sv
bench/tb_rotated_rect_circle_overlap_unit.sv
